### rtl/lce_pkg.sv
// lce_pkg: shared types and constants for the lehmer code encoder
// used by lce_tree_mem and lehmer_code_encoder; no dependencies
`default_nettype none

package lce_pkg;

    // field widths
    localparam int VAL_W    = 10;
    localparam int CNT_W    = 11;
    localparam int STAT_W   = 2;
    localparam int SIZE_W   = 11;
    localparam int EPOCH_W  = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_REPEAT = 2'd2;

    // register map
    localparam logic [CFG_AW-1:0] ADDR_PERM_SIZE = 3'd0;
    localparam logic [SIZE_W-1:0] PERM_SIZE_RST  = 11'd64;

    // highest epoch tag; tag zero marks a swept entry
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 6'd1;

    // count memory control from the sequencer
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_mem_ctl;

endpackage

`default_nettype wire

### rtl/lehmer_code_encoder.sv
// lehmer_code_encoder: top level, sequencer, apb register and result register
// depends on lce_pkg and lce_tree_mem
`default_nettype none

// Lehmer code encoder. Each request carries one permutation value; the block
// returns the Lehmer digit (value minus the count of earlier values not above
// it) and a status. Counting is done with a Fenwick tree held in a single-port
// memory, walked by one adder under a small sequencer: every tree step is a
// read state followed by an add or write state. A repeated value skips the
// update walk, and an out-of-range value skips both walks. A result waiting in
// the output register holds the sequencer in its last state until the result
// is taken. The block takes one request at a time. Clearing on a start request
// uses an epoch tag per entry, so a start costs nothing, except that after
// reset and on every 63rd start the memory is swept once before work goes on.
// perm_size is written over APB at address 0 and is not saturated; values at
// or above MAX_SIZE are still rejected by the range check.
module lehmer_code_encoder #(
    parameter int MAX_SIZE = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // input request channel
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_start_req,
    input  wire [lce_pkg::VAL_W-1:0]      i_value,
    // result channel
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [lce_pkg::VAL_W-1:0]     o_code_value,
    output logic [lce_pkg::STAT_W-1:0]    o_status,
    // configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [lce_pkg::CFG_AW-1:0]     paddr,
    input  wire [lce_pkg::CFG_DW-1:0]     pwdata,
    output logic [lce_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int AW    = $clog2(MAX_SIZE);
    localparam int PW    = AW + 2;
    localparam int SUM_W = lce_pkg::CNT_W + $clog2(AW + 2);
    localparam int CW    = AW + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_QADD  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_URD   = 4'd6;
    localparam logic [3:0] S_UWR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                      r_state, n_state;
    logic [lce_pkg::SIZE_W-1:0]      r_perm_size;
    logic [lce_pkg::EPOCH_W-1:0]     r_epoch, n_epoch;
    logic [CW-1:0]                   r_clr_cnt, n_clr_cnt;
    logic [lce_pkg::VAL_W-1:0]       r_val, n_val;
    logic [PW-1:0]                   r_pos, n_pos;
    logic [SUM_W-1:0]                r_sum, n_sum;
    logic [lce_pkg::VAL_W-1:0]       r_code, n_code;
    logic [lce_pkg::STAT_W-1:0]      r_stat, n_stat;
    logic                            r_out_valid;
    logic [lce_pkg::VAL_W-1:0]       r_out_code;
    logic [lce_pkg::STAT_W-1:0]      r_out_stat;
    logic                            r_clr_flag;

    lce_pkg::t_mem_ctl               mem_ctl;
    logic [AW-1:0]                   mem_addr;
    logic [lce_pkg::CNT_W-1:0]       mem_rcnt;
    logic [PW-1:0]                   pos_m1;
    logic [PW-1:0]                   pos_low;
    logic                            in_acc;
    logic                            out_acc;
    logic                            cfg_wr;
    logic                            out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign pos_m1   = r_pos - PW'(1);
    assign pos_low  = r_pos & (~r_pos + PW'(1));

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        if (paddr[lce_pkg::CFG_AW-1:2] == lce_pkg::ADDR_PERM_SIZE[lce_pkg::CFG_AW-1:2]) begin
            prdata = lce_pkg::CFG_DW'(r_perm_size);
        end else begin
            prdata = '0;
        end
    end

    // count memory
    lce_tree_mem #(
        .DEPTH (MAX_SIZE),
        .AW    (AW)
    ) u_tree_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_epoch (r_epoch),
        .i_wcnt  (mem_rcnt + lce_pkg::CNT_W'(1)),
        .o_rcnt  (mem_rcnt)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_epoch   = r_epoch;
        n_clr_cnt = r_clr_cnt;
        n_val     = r_val;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_code    = r_code;
        n_stat    = r_stat;
        mem_ctl   = '0;
        mem_addr  = pos_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val  = i_value;
                    n_code = '0;
                    n_stat = lce_pkg::STATUS_OK;
                    n_state = S_CHECK;
                    if (i_start_req) begin
                        if (r_epoch == lce_pkg::EPOCH_MAX) begin
                            n_epoch   = lce_pkg::EPOCH_FIRST;
                            n_clr_cnt = '0;
                            n_state   = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + lce_pkg::EPOCH_W'(1);
                        end
                    end
                end
            end
            S_CLEAR: begin
                mem_ctl.wr = 1'b1;
                mem_ctl.clr = 1'b1;
                mem_addr = r_clr_cnt[AW-1:0];
                n_clr_cnt = r_clr_cnt + CW'(1);
                if (r_clr_cnt == CW'(MAX_SIZE - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((lce_pkg::SIZE_W'(r_val) >= r_perm_size) || (32'(r_val) >= MAX_SIZE)) begin
                    n_stat  = lce_pkg::STATUS_RANGE;
                    n_state = S_DONE;
                end else begin
                    n_pos   = PW'(r_val) + PW'(1);
                    n_sum   = '0;
                    n_state = S_QRD;
                end
            end
            // prefix query: read entry then accumulate
            S_QRD: begin
                if (r_pos == '0) begin
                    n_state = S_CMP;
                end else begin
                    mem_ctl.rd = 1'b1;
                    n_state = S_QADD;
                end
            end
            S_QADD: begin
                n_sum   = r_sum + SUM_W'(mem_rcnt);
                n_pos   = r_pos & pos_m1;
                n_state = S_QRD;
            end
            S_CMP: begin
                if (SUM_W'(r_val) < r_sum) begin
                    n_stat  = lce_pkg::STATUS_REPEAT;
                    n_state = S_DONE;
                end else begin
                    n_code  = r_val - r_sum[lce_pkg::VAL_W-1:0];
                    n_pos   = PW'(r_val) + PW'(1);
                    n_state = S_URD;
                end
            end
            // update walk: read entry then write it back plus one
            S_URD: begin
                if (r_pos == '0 || r_pos > PW'(MAX_SIZE)) begin
                    n_state = S_DONE;
                end else begin
                    mem_ctl.rd = 1'b1;
                    n_state = S_UWR;
                end
            end
            S_UWR: begin
                mem_ctl.wr = 1'b1;
                n_pos   = r_pos + pos_low;
                n_state = S_URD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_epoch     <= lce_pkg::EPOCH_FIRST;
            r_clr_cnt   <= '0;
            r_perm_size <= lce_pkg::PERM_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            // the sweep after reset returns to idle rather than to a check
            if (r_state == S_CLEAR && n_state == S_CHECK && !r_clr_flag) begin
                r_state <= S_IDLE;
            end else begin
                r_state <= n_state;
            end
            r_epoch   <= n_epoch;
            r_clr_cnt <= n_clr_cnt;
            if (cfg_wr && paddr[lce_pkg::CFG_AW-1:2] ==
                    lce_pkg::ADDR_PERM_SIZE[lce_pkg::CFG_AW-1:2]) begin
                r_perm_size <= pwdata[lce_pkg::SIZE_W-1:0];
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // marks a sweep started by a request, not by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_flag <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_clr_flag <= in_acc;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_sum  <= n_sum;
        r_code <= n_code;
        r_stat <= n_stat;
        if (r_state == S_DONE && out_free) begin
            r_out_code <= r_code;
            r_out_stat <= r_stat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_value = r_out_code;
    assign o_status     = r_out_stat;

    // tag zero is reserved for swept entries
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch tag reached zero");

    // a rejected value always carries a zero digit
    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != lce_pkg::STATUS_OK) |-> (o_code_value == '0))
        else $error("nonzero digit on error status");

    // an accepted request leads to a range check or a sweep
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK || r_state == S_CLEAR))
        else $error("request not dispatched");

    // a result register is never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwritten");

endmodule

`default_nettype wire

### rtl/lce_tree_mem.sv
// lce_tree_mem: fenwick count memory with epoch tags for fast clearing
// depends on lce_pkg
`default_nettype none

module lce_tree_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                          i_clk,
    input  wire lce_pkg::t_mem_ctl       i_ctl,
    input  wire [AW-1:0]                 i_addr,
    input  wire [lce_pkg::EPOCH_W-1:0]   i_epoch,
    input  wire [lce_pkg::CNT_W-1:0]     i_wcnt,
    output logic [lce_pkg::CNT_W-1:0]    o_rcnt
);

    localparam int WORD_W = lce_pkg::EPOCH_W + lce_pkg::CNT_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            if (i_ctl.clr) begin
                r_mem[i_addr] <= '0;
            end else begin
                r_mem[i_addr] <= {i_epoch, i_wcnt};
            end
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // an entry from an older epoch reads as zero
    always_comb begin
        if (r_rdata[WORD_W-1 -: lce_pkg::EPOCH_W] == i_epoch) begin
            o_rcnt = r_rdata[lce_pkg::CNT_W-1:0];
        end else begin
            o_rcnt = '0;
        end
    end

endmodule

`default_nettype wire
